>>> hdl/wtt_pkg.sv
`timescale 1ns / 1ps

package wtt_pkg;

	localparam int ENTRIES     = 16;
	localparam int MAX_RESULTS = 16;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RIDX_W = $clog2(ENTRIES + 1);
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);

	localparam int WORD_W  = 32;
	localparam int ACT_W   = 3;
	localparam int ST_W    = 3;
	localparam int CNT_W   = 5;
	localparam int SLOT_W  = 4;
	localparam int ENTRY_W = 3 * WORD_W;
	localparam int IN_W    = 104;
	localparam int OUT_W   = 80;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	localparam logic [ACT_W-1:0] ACT_SET       = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CHECK     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 3'd3;
	localparam logic [ACT_W-1:0] ACT_EVENT     = 3'd4;

	localparam logic [ST_W-1:0] ST_OK           = 3'd0;
	localparam logic [ST_W-1:0] ST_ARG_ERR      = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL         = 3'd2;
	localparam logic [ST_W-1:0] ST_FIRED        = 3'd3;
	localparam logic [ST_W-1:0] ST_FIRED_UNIMPL = 3'd4;
	localparam logic [ST_W-1:0] ST_NONE         = 3'd5;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} wtt_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] in_action;
		logic             scan_end;
		logic             fire;
		logic             held_v;
		logic             out_free;
	} wtt_stat_t;

endpackage

>>> hdl/wtt_ram.sv
`timescale 1ns / 1ps

module wtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/wtt_ctrl.sv
`timescale 1ns / 1ps

module wtt_ctrl
	import wtt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  wtt_stat_t stat,
	output wtt_cmd_t  cmd
);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		FIN
	} state_t;

	state_t state_q;

	assign s_tready   = (state_q == IDLE);
	assign cmd.load   = (state_q == IDLE) && s_tvalid;
	assign cmd.step   = (state_q == SCAN) && !(stat.fire && stat.held_v && !stat.out_free);
	assign cmd.finish = (state_q == FIN) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						case (stat.in_action) inside
							ACT_CHECK, ACT_CLEAR, ACT_EVENT: state_q <= SCAN;
							default:                         state_q <= FIN;
						endcase
					end
				end
				SCAN: begin
					if (stat.scan_end) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (stat.out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> hdl/wtt_dp.sv
`timescale 1ns / 1ps

module wtt_dp
	import wtt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IN_W-1:0]   s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,
	output logic              m_tlast,
	input  logic              cfg_valid,
	input  logic [WORD_W-1:0] cfg_data,
	input  wtt_cmd_t          cmd,
	output wtt_stat_t         stat
);

	logic [WORD_W-1:0]  limit_q;
	logic [ENTRIES-1:0] live_q;

	logic [ACT_W-1:0]  act_q;
	logic [WORD_W-1:0] sid_q;
	logic [WORD_W-1:0] mk_q;
	logic [WORD_W-1:0] op_q;

	logic [RIDX_W-1:0] rd_idx_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [CNT_W-1:0]  count_q;
	logic [NRES_W-1:0] n_q;

	logic              held_v_q;
	logic [ST_W-1:0]   held_st_q;
	logic [WORD_W-1:0] held_op_q;
	logic [SLOT_W-1:0] held_slot_q;

	logic              m_tvalid_q;
	logic [ST_W-1:0]   o_st_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic [WORD_W-1:0] o_op_q;
	logic [WORD_W-1:0] o_mk_q;
	logic [SLOT_W-1:0] o_slot_q;
	logic              o_last_q;

	logic [ENTRY_W-1:0] rdata;
	logic [WORD_W-1:0]  e_sound;
	logic [WORD_W-1:0]  e_marker;
	logic [WORD_W-1:0]  e_opcode;
	logic               rd_done;
	logic               issue;
	logic               cmp_live;
	logic               m3;
	logic               fire;
	logic               out_free;
	logic               push_held;
	logic               out_load;
	logic               set_we;
	logic [IDX_W-1:0]   free_idx;
	logic               has_free;

	logic [ST_W-1:0]   fin_st;
	logic [CNT_W-1:0]  fin_cnt;
	logic [WORD_W-1:0] fin_op;
	logic [WORD_W-1:0] fin_mk;
	logic [SLOT_W-1:0] fin_slot;

	assign rd_done  = (rd_idx_q == RIDX_W'(ENTRIES));
	assign issue    = cmd.step && !rd_done;
	assign e_sound  = rdata[WORD_W-1:0];
	assign e_marker = rdata[2*WORD_W-1:WORD_W];
	assign e_opcode = rdata[3*WORD_W-1:2*WORD_W];
	assign cmp_live = live_q[cmp_idx_s1];

	assign m3 = pend_s1 && cmp_live
		&& (sid_q == ALL_ONES || sid_q == e_sound)
		&& (mk_q == ALL_ONES || mk_q == e_marker)
		&& (op_q == ALL_ONES || op_q == e_opcode);

	assign fire = pend_s1 && (act_q == ACT_EVENT) && cmp_live && (e_sound == sid_q)
		&& (n_q < NRES_W'(MAX_RESULTS));

	assign out_free  = !m_tvalid_q || m_tready;
	assign push_held = cmd.step && fire && held_v_q;
	assign out_load  = cmd.finish || push_held;

	always_comb begin
		free_idx = '0;
		has_free = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!has_free && !live_q[i]) begin
				free_idx = IDX_W'(i);
				has_free = 1'b1;
			end
		end
	end

	assign set_we = cmd.finish && (act_q == ACT_SET) && (sid_q != '0) && has_free;

	wtt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (set_we),
		.waddr(free_idx),
		.wdata({op_q, mk_q, sid_q}),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		fin_st   = ST_OK;
		fin_cnt  = '0;
		fin_op   = '0;
		fin_mk   = '0;
		fin_slot = '0;
		unique case (act_q)
			ACT_SET: begin
				if (sid_q == '0) begin
					fin_st = ST_ARG_ERR;
				end else if (!has_free) begin
					fin_st = ST_FULL;
				end
			end
			ACT_CHECK: fin_cnt = count_q;
			ACT_CLEAR, ACT_CLEAR_ALL: fin_st = ST_OK;
			ACT_EVENT: begin
				if (held_v_q) begin
					fin_st   = held_st_q;
					fin_op   = held_op_q;
					fin_mk   = mk_q;
					fin_slot = held_slot_q;
				end else begin
					fin_st = ST_NONE;
				end
			end
			default: fin_st = ST_ARG_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= '0;
			live_q     <= '0;
			pend_s1    <= 1'b0;
			rd_idx_q   <= '0;
			count_q    <= '0;
			n_q        <= '0;
			held_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.load) begin
				pend_s1  <= 1'b0;
				rd_idx_q <= '0;
				count_q  <= '0;
				n_q      <= '0;
				held_v_q <= 1'b0;
			end else if (cmd.step) begin
				pend_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + RIDX_W'(1);
				end
				if (m3 && act_q == ACT_CHECK && count_q != CNT_MAX) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (m3 && act_q == ACT_CLEAR) begin
					live_q[cmp_idx_s1] <= 1'b0;
				end
				if (fire) begin
					live_q[cmp_idx_s1] <= 1'b0;
					n_q                <= n_q + NRES_W'(1);
					held_v_q           <= 1'b1;
				end
			end
			if (set_we) begin
				live_q[free_idx] <= 1'b1;
			end
			if (cmd.finish && act_q == ACT_CLEAR_ALL) begin
				live_q <= '0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tdata[2:0];
			sid_q <= s_tdata[34:3];
			mk_q  <= s_tdata[66:35];
			op_q  <= s_tdata[98:67];
		end
		if (issue) begin
			cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (cmd.step && fire) begin
			held_st_q   <= (e_opcode < limit_q) ? ST_FIRED_UNIMPL : ST_FIRED;
			held_op_q   <= e_opcode;
			held_slot_q <= SLOT_W'(cmp_idx_s1);
		end
		if (cmd.finish) begin
			o_st_q   <= fin_st;
			o_cnt_q  <= fin_cnt;
			o_op_q   <= fin_op;
			o_mk_q   <= fin_mk;
			o_slot_q <= fin_slot;
			o_last_q <= 1'b1;
		end else if (push_held) begin
			o_st_q   <= held_st_q;
			o_cnt_q  <= '0;
			o_op_q   <= held_op_q;
			o_mk_q   <= mk_q;
			o_slot_q <= held_slot_q;
			o_last_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {4'b0, o_slot_q, o_mk_q, o_op_q, o_cnt_q, o_st_q};

	assign stat.in_action = s_tdata[2:0];
	assign stat.scan_end  = rd_done && !pend_s1;
	assign stat.fire      = fire;
	assign stat.held_v    = held_v_q;
	assign stat.out_free  = out_free;

endmodule

>>> hdl/wildcard_trigger_table_top.sv
`timescale 1ns / 1ps
// Set, clear-all and undefined actions: the result word is registered from the FIN state
// once the output register is free. Check, clear and sound event: one slot read per cycle from
// the single RAM read port, held while a fired word waits on m_tready, then the final word.
// No new item is accepted until its final word is loaded into the output register.
// A sound event holds one fired word back so the final one can carry tlast.
// Reset (arst_n low) frees every slot through its live bit and zeroes the opcode limit.

module wildcard_trigger_table_top
	import wtt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // action[2:0], sound_id[34:3], marker[66:35], opcode[98:67]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // status[2:0], match_count[7:3], fired_opcode[39:8],
	                                    // fired_marker[71:40], fired_slot[75:72]
	output logic              m_tlast,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WORD_W-1:0] cfg_data
);

	wtt_cmd_t  cmd;
	wtt_stat_t stat;

	assign cfg_ready = 1'b1;

	wtt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	wtt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
